[rtl/tfd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Telemetry frame deframer package
// Shared constants, command and status types, and the CRC-8 byte update.
// ----------------------------------------------------------------------------
package tfd_pkg;

  localparam int MAX_FRAME_BYTES = 64;
  localparam int STORE_IDX_W     = $clog2(MAX_FRAME_BYTES);

  localparam int BYTE_W  = 8;
  localparam int POS_W   = 7;
  localparam int LEN_W   = 6;
  localparam int TOTAL_W = 7;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ADDR_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ADDR_SECOND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ADDR_THIRD  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP_TYPE   = 2'd3;

  localparam logic [BYTE_W-1:0] RST_ADDR_FIRST  = 8'd234;
  localparam logic [BYTE_W-1:0] RST_ADDR_SECOND = 8'd236;
  localparam logic [BYTE_W-1:0] RST_ADDR_THIRD  = 8'd200;
  localparam logic [BYTE_W-1:0] RST_SKIP_TYPE   = 8'd22;

  localparam logic [BYTE_W-1:0] LEN_MIN = 8'd2;
  localparam logic [BYTE_W-1:0] LEN_MAX = BYTE_W'(MAX_FRAME_BYTES - 2);

  localparam logic [BYTE_W-1:0] CRC_POLY = 8'hD5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_addr;
    logic take_len;
    logic take_data;
    logic rd_start;
    logic rd_issue;
    logic rd_next;
  } tfd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_addr;
    logic len_ok;
    logic data_end;
    logic frame_good;
    logic rd_last;
  } tfd_sts_t;

  // CRC-8 DVB-S2, MSB first, one byte per call.
  function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] c;
    c = crc ^ b;
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[BYTE_W-1]) begin
        c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[BYTE_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

[rtl/tfd_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Telemetry frame deframer controller
// Parse state machine and replay sequencing for the frame store.
// ----------------------------------------------------------------------------
module tfd_ctrl
  import tfd_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  input  wire tfd_sts_t sts_i,
  output tfd_cmd_t      cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LEN  = 3'd1;
  localparam logic [2:0] S_DATA = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state_q, state_d;
  logic       in_beat;

  assign in_ready_o  = (state_q == S_IDLE) || (state_q == S_LEN) || (state_q == S_DATA);
  assign out_valid_o = (state_q == S_OUT);
  assign in_beat     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_beat && sts_i.is_addr) begin
          cmd_o.take_addr = 1'b1;
          state_d         = S_LEN;
        end
      end
      S_LEN: begin
        if (in_beat) begin
          if (sts_i.len_ok) begin
            cmd_o.take_len = 1'b1;
            state_d        = S_DATA;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_DATA: begin
        if (in_beat) begin
          cmd_o.take_data = 1'b1;
          if (sts_i.data_end) begin
            if (sts_i.frame_good) begin
              cmd_o.rd_start = 1'b1;
              state_d        = S_RD;
            end else begin
              state_d = S_IDLE;
            end
          end
        end
      end
      S_RD: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) begin
          if (sts_i.rd_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.rd_next = 1'b1;
            state_d       = S_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // The input side is held off for the whole replay of a frame.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input accepted while a frame is being replayed");

  // A replay starts only from a data beat that closes the frame.
  a_start_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_start |-> (state_q == S_DATA) && in_beat && sts_i.data_end)
    else $error("replay started outside the end of a frame");

  // After the final byte of a frame goes out, parsing resumes.
  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && sts_i.rd_last) |=> (state_q == S_IDLE))
    else $error("controller did not return to idle after the last byte");

endmodule
`default_nettype wire

[rtl/tfd_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Telemetry frame deframer datapath
// Configuration registers, frame store, running CRC and replay counter.
// ----------------------------------------------------------------------------
module tfd_dp
  import tfd_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [BYTE_W-1:0]    cfg_data_i,
  input  wire logic [BYTE_W-1:0]    in_byte_i,
  input  wire tfd_cmd_t             cmd_i,
  output tfd_sts_t                  sts_o,
  output logic [BYTE_W-1:0]         out_byte_o,
  output logic [TOTAL_W-1:0]        frame_total_o,
  output logic                      last_byte_o
);

  logic [BYTE_W-1:0]  addr_first_q, addr_second_q, addr_third_q, skip_type_q;
  logic [POS_W-1:0]   wpos_q, wpos_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic [BYTE_W-1:0]  crc_q, crc_d;
  logic [BYTE_W-1:0]  type_q;
  logic [TOTAL_W-1:0] total;
  logic [TOTAL_W-1:0] rd_idx_q, rd_idx_d;
  logic [BYTE_W-1:0]  rd_data_q;

  logic [BYTE_W-1:0]      mem [MAX_FRAME_BYTES];
  logic                   mem_we;
  logic [STORE_IDX_W-1:0] mem_waddr;
  logic [POS_W-1:0]       wpos_inc;

  assign total    = {1'b0, len_q} + TOTAL_W'(2);
  assign wpos_inc = wpos_q + POS_W'(1);

  always_comb begin
    sts_o.is_addr    = (in_byte_i == addr_first_q) || (in_byte_i == addr_second_q) ||
                       (in_byte_i == addr_third_q);
    sts_o.len_ok     = (in_byte_i >= LEN_MIN) && (in_byte_i <= LEN_MAX);
    sts_o.data_end   = (wpos_inc == POS_W'(total));
    sts_o.frame_good = (crc_q == in_byte_i) && (type_q != skip_type_q);
    sts_o.rd_last    = (rd_idx_q == total - TOTAL_W'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_first_q  <= RST_ADDR_FIRST;
      addr_second_q <= RST_ADDR_SECOND;
      addr_third_q  <= RST_ADDR_THIRD;
      skip_type_q   <= RST_SKIP_TYPE;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ADDR_FIRST:  addr_first_q  <= cfg_data_i;
        CFG_ADDR_SECOND: addr_second_q <= cfg_data_i;
        CFG_ADDR_THIRD:  addr_third_q  <= cfg_data_i;
        CFG_SKIP_TYPE:   skip_type_q   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    wpos_d    = wpos_q;
    len_d     = len_q;
    crc_d     = crc_q;
    rd_idx_d  = rd_idx_q;
    mem_we    = 1'b0;
    mem_waddr = wpos_q[STORE_IDX_W-1:0];
    if (cmd_i.take_addr) begin
      mem_we    = 1'b1;
      mem_waddr = STORE_IDX_W'(0);
      wpos_d    = POS_W'(1);
    end
    if (cmd_i.take_len) begin
      mem_we    = 1'b1;
      mem_waddr = STORE_IDX_W'(1);
      wpos_d    = POS_W'(2);
      len_d     = in_byte_i[LEN_W-1:0];
      crc_d     = '0;
    end
    if (cmd_i.take_data) begin
      mem_we = 1'b1;
      wpos_d = wpos_inc;
      // The closing check byte itself stays out of the CRC.
      if (!sts_o.data_end) begin
        crc_d = crc8_byte(crc_q, in_byte_i);
      end
    end
    if (cmd_i.rd_start) begin
      rd_idx_d = '0;
    end
    if (cmd_i.rd_next) begin
      rd_idx_d = rd_idx_q + TOTAL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpos_q   <= '0;
      len_q    <= '0;
      crc_q    <= '0;
      rd_idx_q <= '0;
    end else begin
      wpos_q   <= wpos_d;
      len_q    <= len_d;
      crc_q    <= crc_d;
      rd_idx_q <= rd_idx_d;
    end
  end

  // The type byte is kept aside so the end-of-frame decision needs no store read.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_data && (wpos_q == POS_W'(2))) begin
      type_q <= in_byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= in_byte_i;
    end
    if (cmd_i.rd_issue) begin
      rd_data_q <= mem[rd_idx_q[STORE_IDX_W-1:0]];
    end
  end

  assign out_byte_o    = rd_data_q;
  assign frame_total_o = total;
  assign last_byte_o   = sts_o.rd_last;

  a_rd_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_issue |-> (rd_idx_q < total))
    else $error("replay read beyond the end of the frame");

  a_wr_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.take_data |-> (POS_W'(total) > wpos_q))
    else $error("frame byte written beyond the frame length");

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.take_len |=> (total >= TOTAL_W'(4)) &&
                       (total <= TOTAL_W'(MAX_FRAME_BYTES)))
    else $error("accepted frame length out of range");

endmodule
`default_nettype wire

[rtl/telemetry_frame_deframer.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Telemetry frame deframer
// Byte-serial link deframer with CRC-8 check and frame replay.
// ----------------------------------------------------------------------------
// While parsing, the block takes one link byte per cycle: it waits for one of
// three address bytes, checks the length byte, stores the frame and runs a
// CRC-8 (polynomial 0xD5) over type and payload. A frame whose check byte
// matches and whose type is not the skipped type is replayed from the frame
// store, address first, with its total length and a last flag on every beat.
// Replay is a sequence of store reads: the read state issues the registered
// store read and the output state then presents the byte, and the controller
// waits for that beat to be taken before it issues the next read, so a new
// read never starts before the last byte is taken. No input beat is accepted
// during replay. Configuration writes are always ready and must be issued
// only while the block is idle.
module telemetry_frame_deframer
  import tfd_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [BYTE_W-1:0]    cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [BYTE_W-1:0]    in_byte_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [BYTE_W-1:0]         out_byte_o,
  output logic [TOTAL_W-1:0]        frame_total_o,
  output logic                      last_byte_o
);

  tfd_cmd_t cmd;
  tfd_sts_t sts;

  assign cfg_ready_o = 1'b1;

  tfd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tfd_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_byte_i     (in_byte_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_byte_o    (out_byte_o),
    .frame_total_o (frame_total_o),
    .last_byte_o   (last_byte_o)
  );

endmodule
`default_nettype wire
